>>> hw/rtl/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg - shared types and constants for barometric compensation
// Holds the decoded coefficient set, the pipeline payload record and the
// arithmetic helpers used across the stages.
// ----------------------------------------------------------------------------
package bpt_pkg;

	localparam int DIV_W = 32;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B1_B2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MC_MD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OSS = 3'd5;

	localparam logic [31:0] TEMP_OFFSET_B6 = 32'd4000;
	localparam logic [31:0] B4_BIAS = 32'd32768;
	localparam logic [31:0] B7_SCALE = 32'd50000;
	localparam logic [31:0] PC_X1_MUL = 32'd3038;
	localparam logic [31:0] PC_X2_MUL = 32'hFFFF_E343; // minus 7357
	localparam logic [31:0] PC_ADD = 32'd3791;

	// Calibration words, already widened to 32 bits with their proper sign.
	typedef struct packed {
		logic [31:0] ac1;
		logic [31:0] ac2;
		logic [31:0] ac3;
		logic [31:0] ac4;
		logic [31:0] ac5;
		logic [31:0] ac6;
		logic [31:0] b1;
		logic [31:0] b2;
		logic [31:0] mc;
		logic [31:0] md;
		logic [1:0]  oss;
	} cfg_t;

	// Everything one item carries down the pipeline.
	typedef struct packed {
		logic [15:0] ut;
		logic [18:0] up;
		logic        fault;
		logic        neg;
		logic        big;
		logic [31:0] m;
		logic [31:0] x1;
		logic [31:0] num;
		logic [31:0] den;
		logic [31:0] b5;
		logic [31:0] b6;
		logic [31:0] p1;
		logic [31:0] sq;
		logic [31:0] p2;
		logic [31:0] p3;
		logic [31:0] p4;
		logic [31:0] p5;
		logic [31:0] b3;
		logic [31:0] y;
		logic [31:0] p6;
		logic [31:0] b4;
		logic [31:0] d7;
		logic [31:0] b7;
		logic [31:0] p;
		logic [31:0] pp;
		logic [31:0] pq;
		logic [31:0] x2;
		logic [15:0] temp;
		logic [31:0] press;
	} pl_t;

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
		asr = 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] v);
		sext16 = {{16{v[15]}}, v};
	endfunction

endpackage

>>> hw/rtl/bpt_cfg.sv
// ----------------------------------------------------------------------------
// bpt_cfg - calibration and oversampling registers
// Stores the packed calibration words and presents them decoded.
// ----------------------------------------------------------------------------
module bpt_cfg import bpt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output cfg_t                 coef
);

	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0]  oss_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0;
			ac34_q <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
			oss_q  <= 2'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_AC1_AC2: ac12_q <= cfg_data;
				REG_AC3_AC4: ac34_q <= cfg_data;
				REG_AC5_AC6: ac56_q <= cfg_data;
				REG_B1_B2:   b12_q  <= cfg_data;
				REG_MC_MD:   mcmd_q <= cfg_data;
				REG_OSS:     oss_q  <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		coef.ac1 = sext16(ac12_q[31:16]);
		coef.ac2 = sext16(ac12_q[15:0]);
		coef.ac3 = sext16(ac34_q[31:16]);
		coef.ac4 = {16'd0, ac34_q[15:0]};
		coef.ac5 = {16'd0, ac56_q[31:16]};
		coef.ac6 = {16'd0, ac56_q[15:0]};
		coef.b1  = sext16(b12_q[31:16]);
		coef.b2  = sext16(b12_q[15:0]);
		coef.mc  = sext16(mcmd_q[31:16]);
		coef.md  = sext16(mcmd_q[15:0]);
		coef.oss = oss_q;
	end

endmodule

>>> hw/rtl/bpt_div.sv
// ----------------------------------------------------------------------------
// bpt_div - pipelined unsigned restoring divider
// One quotient bit per stage; the item record travels alongside.
// ----------------------------------------------------------------------------
module bpt_div import bpt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	input  pl_t              in_rec,
	output logic             out_vld,
	output logic [DIV_W-1:0] quotient,
	output pl_t              out_rec
);

	logic             vld_s [DIV_W+1];
	logic [DIV_W-1:0] rem_s [DIV_W+1];
	logic [DIV_W-1:0] quo_s [DIV_W+1];
	logic [DIV_W-1:0] dsr_s [DIV_W+1];
	pl_t              rec_s [DIV_W+1];

	assign vld_s[0] = in_vld;
	assign rem_s[0] = '0;
	assign quo_s[0] = dividend;
	assign dsr_s[0] = divisor;
	assign rec_s[0] = in_rec;

	for (genvar k = 0; k < DIV_W; k++) begin : g_step
		logic [DIV_W:0]   trial;
		logic [DIV_W:0]   diff;
		logic             take;

		assign trial = {rem_s[k], quo_s[k][DIV_W-1]};
		assign diff  = trial - {1'b0, dsr_s[k]};
		assign take  = !diff[DIV_W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
				quo_s[k+1] <= {quo_s[k][DIV_W-2:0], take};
				dsr_s[k+1] <= dsr_s[k];
				rec_s[k+1] <= rec_s[k];
			end
		end
	end

	assign out_vld  = vld_s[DIV_W];
	assign quotient = quo_s[DIV_W];
	assign out_rec  = rec_s[DIV_W];

endmodule

>>> hw/rtl/baro_pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top - integer barometer compensation
// Turns a raw temperature word and a raw pressure reading into temperature
// in tenths of a degree and pressure in pascals, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Beat contents
//  raw       in         raw_valid/raw_ready    raw_temp, raw_press
//  res       out        res_valid/res_ready    temperature, pressure, div_fault
//  cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One beat may enter every cycle while the output is not stalled. The depth is
// set by nineteen arithmetic stages plus two 32-stage dividers, one quotient
// bit per stage. Reset clears every valid bit; payload registers are not reset.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stalled output freezes every stage and nothing is lost
// or repeated. Configuration writes are always accepted.
//
module baro_pressure_temp_compensation_top import bpt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 raw_valid,
	output logic                 raw_ready,
	input  logic [15:0]          raw_temp,
	input  logic [18:0]          raw_press,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic signed [15:0]   temperature,
	output logic signed [31:0]   pressure,
	output logic                 div_fault,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t coef;
	logic en;

	// Stage valid bits and records.  Stages 1 to 3 lead into the temperature
	// divider, 4 to 14 into the pressure divider, 15 to 19 finish the result.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19;
	pl_t  d_s1, d_s2, d_s3, d_s4, d_s5, d_s6, d_s7, d_s8, d_s9, d_s10;
	pl_t  d_s11, d_s12, d_s13, d_s14, d_s15, d_s16, d_s17, d_s18, d_s19;

	// Next contents of each stage record, built before the register edge.
	pl_t  pl1_c, pl2_c, pl3_c, pl4_c, pl5_c, pl6_c, pl7_c, pl8_c, pl9_c, pl10_c;
	pl_t  pl11_c, pl12_c, pl13_c, pl14_c, pl15_c, pl16_c, pl17_c, pl18_c, pl19_c;

	logic        tdiv_vld, pdiv_vld;
	logic [31:0] tdiv_q, pdiv_q;
	pl_t         tdiv_rec, pdiv_rec;

	// Combinational helpers for the busier stages.
	logic [31:0] x2_t, b5_t, temp_t;
	logic [31:0] x3_c, t_c, v_c, y_c, b4_c;
	logic [31:0] p_c, s8_c, x1_c, press_c;

	bpt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	// The only flow control: the output register is free or is being taken.
	assign en        = !v_s19 || res_ready;
	assign raw_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
		end else if (en) begin
			v_s1  <= raw_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= tdiv_vld;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= pdiv_vld;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
			v_s18 <= v_s17;
			v_s19 <= v_s18;
		end
	end

	// Temperature: x1 = ((ut - ac6) * ac5) >> 15, divisor is x1 + md.
	always_comb begin
		pl1_c    = '0;
		pl1_c.ut = raw_temp;
		pl1_c.up = raw_press;
		pl1_c.m  = ({16'd0, raw_temp} - coef.ac6) * coef.ac5;

		pl2_c       = d_s1;
		pl2_c.x1    = asr(d_s1.m, 5'd15);
		pl2_c.den   = pl2_c.x1 + coef.md;
		pl2_c.num   = coef.mc << 11;
		pl2_c.fault = pl2_c.den == 32'd0;

		// Signed division runs on magnitudes; the sign is put back after.
		pl3_c     = d_s2;
		pl3_c.num = d_s2.num[31] ? 32'd0 - d_s2.num : d_s2.num;
		pl3_c.den = d_s2.den[31] ? 32'd0 - d_s2.den : d_s2.den;
		pl3_c.neg = d_s2.num[31] ^ d_s2.den[31];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= pl1_c;
			d_s2 <= pl2_c;
			d_s3 <= pl3_c;
		end
	end

	bpt_div u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s3),
		.dividend (d_s3.num),
		.divisor  (d_s3.den),
		.in_rec   (d_s3),
		.out_vld  (tdiv_vld),
		.quotient (tdiv_q),
		.out_rec  (tdiv_rec)
	);

	assign x2_t   = tdiv_rec.neg ? 32'd0 - tdiv_q : tdiv_q;
	assign b5_t   = tdiv_rec.x1 + x2_t;
	assign temp_t = asr(b5_t + 32'd8, 5'd4);

	// Pressure coefficients b3 and b4.  The signed divide of b3 by four
	// truncates toward zero, hence the negate around the shift.
	assign x3_c = asr(d_s9.p3, 5'd11) + asr(d_s9.p2, 5'd11);
	assign t_c  = ((coef.ac1 << 2) + x3_c) << coef.oss;
	assign v_c  = t_c + 32'd2;
	assign y_c  = asr(asr(d_s9.p4, 5'd13) + asr(d_s9.p5, 5'd16) + 32'd2, 5'd2);
	assign b4_c = d_s11.p6 >> 15;

	always_comb begin
		pl4_c      = tdiv_rec;
		pl4_c.b5   = b5_t;
		pl4_c.b6   = b5_t - TEMP_OFFSET_B6;
		pl4_c.temp = temp_t[15:0];

		pl5_c    = d_s4;
		pl5_c.p1 = d_s4.b6 * d_s4.b6;

		pl6_c    = d_s5;
		pl6_c.sq = asr(d_s5.p1, 5'd12);
		pl6_c.p2 = coef.ac2 * d_s5.b6;

		pl7_c    = d_s6;
		pl7_c.p3 = coef.b2 * d_s6.sq;

		pl8_c    = d_s7;
		pl8_c.p4 = coef.ac3 * d_s7.b6;

		pl9_c    = d_s8;
		pl9_c.p5 = coef.b1 * d_s8.sq;

		pl10_c    = d_s9;
		pl10_c.b3 = v_c[31] ? 32'd0 - ((32'd0 - v_c) >> 2) : v_c >> 2;
		pl10_c.y  = y_c;

		pl11_c    = d_s10;
		pl11_c.p6 = coef.ac4 * (d_s10.y + B4_BIAS);

		pl12_c       = d_s11;
		pl12_c.b4    = b4_c;
		pl12_c.fault = d_s11.fault || (b4_c == 32'd0);
		pl12_c.d7    = {13'd0, d_s11.up} - d_s11.b3;

		pl13_c    = d_s12;
		pl13_c.b7 = d_s12.d7 * (B7_SCALE >> coef.oss);

		// Below 2^31 the doubling is done before the divide, else after.
		pl14_c     = d_s13;
		pl14_c.big = d_s13.b7[31];
		pl14_c.num = d_s13.b7[31] ? d_s13.b7 : d_s13.b7 << 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4  <= pl4_c;
			d_s5  <= pl5_c;
			d_s6  <= pl6_c;
			d_s7  <= pl7_c;
			d_s8  <= pl8_c;
			d_s9  <= pl9_c;
			d_s10 <= pl10_c;
			d_s11 <= pl11_c;
			d_s12 <= pl12_c;
			d_s13 <= pl13_c;
			d_s14 <= pl14_c;
		end
	end

	bpt_div u_pdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s14),
		.dividend (d_s14.num),
		.divisor  (d_s14.b4),
		.in_rec   (d_s14),
		.out_vld  (pdiv_vld),
		.quotient (pdiv_q),
		.out_rec  (pdiv_rec)
	);

	assign p_c     = pdiv_rec.big ? pdiv_q << 1 : pdiv_q;
	assign s8_c    = asr(d_s15.p, 5'd8);
	assign x1_c    = asr(d_s18.pq, 5'd16);
	assign press_c = d_s18.p + asr(x1_c + asr(d_s18.x2, 5'd16) + PC_ADD, 5'd4);

	always_comb begin
		pl15_c   = pdiv_rec;
		pl15_c.p = p_c;

		pl16_c    = d_s15;
		pl16_c.pp = s8_c * s8_c;

		pl17_c    = d_s16;
		pl17_c.pq = d_s16.pp * PC_X1_MUL;

		pl18_c    = d_s17;
		pl18_c.x2 = PC_X2_MUL * d_s17.p;

		pl19_c       = d_s18;
		pl19_c.press = d_s18.fault ? 32'd0 : press_c;
		pl19_c.temp  = d_s18.fault ? 16'd0 : d_s18.temp;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s15 <= pl15_c;
			d_s16 <= pl16_c;
			d_s17 <= pl17_c;
			d_s18 <= pl18_c;
			d_s19 <= pl19_c;
		end
	end

	assign res_valid   = v_s19;
	assign temperature = d_s19.temp;
	assign pressure    = d_s19.press;
	assign div_fault   = d_s19.fault;

endmodule

>>> sim/tb_baro_pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation_top - self-checking barometer compensation test
// Drives raw reading pairs through the valid/ready input channel, predicts the
// compensated temperature, pressure and fault flag for every accepted beat,
// and checks each result beat in order while both channels idle at random.
// Coefficients are changed between phases only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_baro_pressure_temp_compensation_top;
	import bpt_pkg::*;

	localparam int LATENCY = 83;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BEATS = 1750;
	localparam int PHASES = 7;

	logic clk;
	logic arst_n;
	logic raw_valid;
	logic raw_ready;
	logic [15:0] raw_temp;
	logic [18:0] raw_press;
	logic res_valid;
	logic res_ready;
	logic signed [15:0] temperature;
	logic signed [31:0] pressure;
	logic div_fault;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	// One predicted result beat.
	typedef struct {
		logic [15:0] temp;
		logic [31:0] press;
		logic fault;
	} comp_t;

	// One row of the directed table; check_fixed marks rows whose answer is typed in.
	typedef struct {
		logic [15:0] ut;
		logic [18:0] up;
		bit check_fixed;
		comp_t fixed;
	} row_t;

	comp_t pending_results[$];
	logic [31:0] cal_words[0:4];
	logic [1:0] cal_oss;
	int mismatches;
	int cycles;

	baro_pressure_temp_compensation_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.raw_valid(raw_valid),
		.raw_ready(raw_ready),
		.raw_temp(raw_temp),
		.raw_press(raw_press),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.temperature(temperature),
		.pressure(pressure),
		.div_fault(div_fault),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Arithmetic shift right on a 32-bit word.
	function automatic logic [31:0] shr_s(input logic [31:0] v, input int n);
		return 32'($signed(v) >>> n);
	endfunction

	// Signed division that truncates towards zero, done on magnitudes.
	function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	// Works out the compensated reading from the current calibration copy.
	function automatic comp_t compensate(input logic [15:0] ut, input logic [18:0] up);
		comp_t r;
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den, t;
		int oss;
		oss = cal_oss;
		ac1 = {{16{cal_words[0][31]}}, cal_words[0][31:16]};
		ac2 = {{16{cal_words[0][15]}}, cal_words[0][15:0]};
		ac3 = {{16{cal_words[1][31]}}, cal_words[1][31:16]};
		ac4 = {16'd0, cal_words[1][15:0]};
		ac5 = {16'd0, cal_words[2][31:16]};
		ac6 = {16'd0, cal_words[2][15:0]};
		b1 = {{16{cal_words[3][31]}}, cal_words[3][31:16]};
		b2 = {{16{cal_words[3][15]}}, cal_words[3][15:0]};
		mc = {{16{cal_words[4][31]}}, cal_words[4][31:16]};
		md = {{16{cal_words[4][15]}}, cal_words[4][15:0]};
		r.temp = '0;
		r.press = '0;
		r.fault = 1'b1;
		x1 = shr_s((32'(ut) - ac6) * ac5, 15);
		den = x1 + md;
		if (den == 0)
			return r;
		x2 = div_trunc(mc << 11, den);
		b5 = x1 + x2;
		t = shr_s(b5 + 32'd8, 4);
		b6 = b5 - 32'd4000;
		sq = shr_s(b6 * b6, 12);
		x1 = shr_s(b2 * sq, 11);
		x2 = shr_s(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = div_trunc(((ac1 * 32'd4 + x3) << oss) + 32'd2, 32'd4);
		x1 = shr_s(ac3 * b6, 13);
		x2 = shr_s(b1 * sq, 16);
		x3 = shr_s(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		if (b4 == 0)
			return r;
		b7 = (32'(up) - b3) * (32'd50000 >> oss);
		if (b7 < 32'h8000_0000)
			p = (b7 * 32'd2) / b4;
		else
			p = (b7 / b4) * 32'd2;
		x1 = shr_s(p, 8) * shr_s(p, 8);
		x1 = shr_s(x1 * 32'd3038, 16);
		x2 = shr_s(-32'd7357 * p, 16);
		r.temp = t[15:0];
		r.press = p + shr_s(x1 + x2 + 32'd3791, 4);
		r.fault = 1'b0;
		return r;
	endfunction

	// Cycle counter and the hard stop.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver: stalls on a repeating pattern with random stretches mixed in,
	// and compares each accepted result beat with the oldest prediction.
	logic [15:0] stall_pattern;
	int stall_pos;
	always @(posedge clk or negedge arst_n) begin
		comp_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_pos <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("Unexpected result beat: temp %0d press %0d fault %0b",
							temperature, pressure, div_fault);
				end else begin
					want = pending_results.pop_front();
					if (want.temp !== temperature || want.press !== pressure ||
						want.fault !== div_fault) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("Mismatch: want t=%0d p=%0d f=%0b got t=%0d p=%0d f=%0b",
								$signed(want.temp), $signed(want.press), want.fault,
								temperature, pressure, div_fault);
					end
				end
			end
			stall_pos <= stall_pos + 1;
			// Whenever bits 9:8 of the stall counter are both set, the receiver never stalls.
			if (stall_pos[9:8] == 2'd3)
				res_ready <= 1'b1;
			else
				res_ready <= stall_pattern[stall_pos[3:0]] | ($urandom_range(0, 3) != 0);
		end
	end

	// Holds one input beat until it is taken; raw_valid stays high across a
	// run of back-to-back beats, so it is never dropped and raised in one step.
	task automatic send_reading(input logic [15:0] ut, input logic [18:0] up);
		raw_valid <= 1'b1;
		raw_temp <= ut;
		raw_press <= up;
		@(posedge clk);
		while (!raw_ready)
			@(posedge clk);
		pending_results.push_back(compensate(ut, up));
	endtask

	task automatic idle_gap(input int n);
		raw_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Waits until every predicted beat has come back, then lets the pipe drain.
	task automatic drain_pipe();
		raw_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		raw_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_AC1_AC2: cal_words[0] = data;
			REG_AC3_AC4: cal_words[1] = data;
			REG_AC5_AC6: cal_words[2] = data;
			REG_B1_B2: cal_words[3] = data;
			REG_MC_MD: cal_words[4] = data;
			REG_OSS: cal_oss = data[1:0];
			default: ;
		endcase
	endtask

	// Loads a whole calibration set and an oversampling setting.
	task automatic load_cal(input logic [31:0] w0, w1, w2, w3, w4, input logic [31:0] os);
		write_reg(REG_AC1_AC2, w0);
		write_reg(REG_AC3_AC4, w1);
		write_reg(REG_AC5_AC6, w2);
		write_reg(REG_B1_B2, w3);
		write_reg(REG_MC_MD, w4);
		write_reg(REG_OSS, os);
	endtask

	// Datasheet-like calibration with random offsets on even phases, fully random words on odd ones.
	task automatic load_random_cal(input int phase);
		logic [31:0] w[0:4];
		foreach (w[i])
			w[i] = $urandom();
		if (phase % 2 == 0) begin
			w[0] = {16'(408 + $urandom_range(0, 200)), 16'(-72 + $urandom_range(0, 40))};
			w[1] = {16'(-14383 + $urandom_range(0, 500)), 16'(32741 + $urandom_range(0, 200))};
			w[2] = {16'(32757 + $urandom_range(0, 200)), 16'(23153 + $urandom_range(0, 500))};
			w[3] = {16'(6190 + $urandom_range(0, 100)), 16'(4 + $urandom_range(0, 8))};
			w[4] = {16'(-8711 + $urandom_range(0, 200)), 16'(2868 + $urandom_range(0, 100))};
		end
		load_cal(w[0], w[1], w[2], w[3], w[4], $urandom_range(0, 3));
	endtask

	row_t directed[$];
	comp_t zero_fault;

	initial begin
		comp_t got;
		arst_n = 1'b0;
		raw_valid = 1'b0;
		raw_temp = '0;
		raw_press = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		cycles = 0;
		stall_pattern = 16'hB6DB;
		foreach (cal_words[i])
			cal_words[i] = '0;
		cal_oss = 2'd3;
		zero_fault = '{temp: 16'd0, press: 32'd0, fault: 1'b1};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset every coefficient is zero, so x1 + md is zero and every
		// reading ends in the divide fault.
		directed.push_back('{16'h0000, 19'h00000, 1'b1, zero_fault});
		directed.push_back('{16'hFFFF, 19'h7FFFF, 1'b1, zero_fault});
		foreach (directed[i]) begin
			send_reading(directed[i].ut, directed[i].up);
			got = compensate(directed[i].ut, directed[i].up);
			if (directed[i].check_fixed) begin
				if (got.temp !== directed[i].fixed.temp ||
					got.press !== directed[i].fixed.press ||
					got.fault !== directed[i].fixed.fault)
					$display("Predictor disagrees with directed row %0d", i);
				pending_results[$] = directed[i].fixed;
			end
		end
		drain_pipe();

		// Typical calibration: extremes of both fields, the large-b7 path and
		// the zero b4 case once ac4 is cleared.
		load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
			{16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 32'd0);
		directed.delete();
		directed.push_back('{16'd27898, 19'd23843, 1'b0, zero_fault});
		directed.push_back('{16'h0000, 19'h00000, 1'b0, zero_fault});
		directed.push_back('{16'hFFFF, 19'h7FFFF, 1'b0, zero_fault});
		directed.push_back('{16'h8000, 19'h40000, 1'b0, zero_fault});
		directed.push_back('{16'h5555, 19'h2AAAA, 1'b0, zero_fault});
		directed.push_back('{16'hAAAA, 19'h55555, 1'b0, zero_fault});
		directed.push_back('{16'd23153, 19'd0, 1'b0, zero_fault});
		foreach (directed[i])
			send_reading(directed[i].ut, directed[i].up);
		drain_pipe();
		for (int os = 1; os < 4; os++) begin
			write_reg(REG_OSS, os);
			send_reading(16'd27898, 19'd23843 << os);
			send_reading(16'hFFFF, 19'h7FFFF);
			drain_pipe();
		end
		// A clear ac4 makes b4 zero; the fault must come back with zeros.
		write_reg(REG_AC3_AC4, 32'hC7D1_0000);
		send_reading(16'd27898, 19'd23843);
		pending_results[$] = zero_fault;
		drain_pipe();
		// An index past the last register must leave the set untouched.
		write_reg(3'd7, 32'hFFFF_FFFF);
		write_reg(3'd6, 32'h1234_5678);
		send_reading(16'd27898, 19'd23843);
		drain_pipe();
		// Extreme coefficients, all ones then a wide mix, exercise the wrap.
		load_cal('1, '1, '1, '1, 32'h8000_7FFF, 32'd3);
		send_reading(16'h0000, 19'h7FFFF);
		send_reading(16'hFFFF, 19'h00000);
		drain_pipe();
		load_cal(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_0001, 32'h7FFF_8000, 32'h7FFF_0001, 32'd1);
		send_reading(16'h1234, 19'h12345);
		send_reading(16'hFEDC, 19'h6DCBA);
		drain_pipe();

		// Random part: bursts and gaps, with a full drain between phases.
		for (int ph = 0; ph < PHASES; ph++) begin
			load_random_cal(ph);
			for (int n = 0; n < RANDOM_BEATS / PHASES; ) begin
				int burst;
				burst = $urandom_range(1, 24);
				for (int k = 0; k < burst; k++, n++) begin
					if (ph % 2 == 0)
						send_reading(16'($urandom_range(20000, 36000)), 19'($urandom()));
					else
						send_reading(16'($urandom()), 19'($urandom()));
				end
				// Once in a while the sender holds off until the pipe is empty.
				if ($urandom_range(0, 40) == 0)
					drain_pipe();
				else if ($urandom_range(0, 2) != 0)
					idle_gap($urandom_range(1, 12));
			end
			drain_pipe();
		end

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
